// ----- rtl/core/nnck_pkg.sv -----
package nnck_pkg;

  // Field and storage widths
  localparam int ELEM_W    = 16;
  localparam int ACC_W     = 48;
  localparam int CNT_W     = 11;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 32;
  localparam int MAX_LENGTH = 1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_LS_SQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE  = 2'd1;
  localparam logic [CFG_W-1:0]     CFG_RESET     = 32'h0001_0000;

  // Fixed-point constants
  localparam logic signed [ACC_W-1:0] ONE_Q16     = 48'sd65536;
  localparam logic [63:0]             ONE_Q30     = 64'd1073741824;
  localparam logic signed [33:0]      HALF_PI_Q30 = 34'sd1686629713;

  // Datapath operations
  typedef logic [4:0] op_t;
  localparam op_t OP_NOP    = 5'd0;
  localparam op_t OP_PREP   = 5'd1;
  localparam op_t OP_GLO    = 5'd2;
  localparam op_t OP_GHI    = 5'd3;
  localparam op_t OP_GWR    = 5'd4;
  localparam op_t OP_NORM   = 5'd5;
  localparam op_t OP_SQ_GO  = 5'd6;
  localparam op_t OP_SQ_WR  = 5'd7;
  localparam op_t OP_MULD   = 5'd8;
  localparam op_t OP_DWR    = 5'd9;
  localparam op_t OP_DIV_GO = 5'd10;
  localparam op_t OP_RWR    = 5'd11;
  localparam op_t OP_HINIT  = 5'd12;
  localparam op_t OP_HMUL   = 5'd13;
  localparam op_t OP_HADD   = 5'd14;
  localparam op_t OP_MULSA  = 5'd15;
  localparam op_t OP_AWR    = 5'd16;
  localparam op_t OP_MULVA  = 5'd17;
  localparam op_t OP_OUT    = 5'd18;

  // Operand / destination selects
  typedef logic [1:0] tgt_t;
  localparam tgt_t TGT_U = 2'd0;
  localparam tgt_t TGT_V = 2'd1;
  localparam tgt_t TGT_W = 2'd2;
  localparam tgt_t TGT_S = 2'd3;

  typedef struct packed {
    logic acc;
    op_t  op;
    tgt_t tgt;
  } dp_cmd_t;

  typedef struct packed {
    logic normed;
    logic mu_zero;
    logic sq_busy;
    logic div_busy;
    logic h_last;
  } dp_stat_t;

  // Arcsine minimax coefficients, Q30
  function automatic logic signed [32:0] asin_coef(input logic [2:0] idx);
    logic signed [32:0] c;
    unique case (idx)
      3'd0: c = 33'sd1686629690;
      3'd1: c = -33'sd230423709;
      3'd2: c = 33'sd95540460;
      3'd3: c = -33'sd53874249;
      3'd4: c = 33'sd33169905;
      3'd5: c = -33'sd18348235;
      3'd6: c = 33'sd7161955;
      3'd7: c = -33'sd1355590;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/nnck_if.sv -----
// Element pair channel
interface nnck_item_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_elem;
  logic signed [15:0] b_elem;
  logic               last;

  modport source (output valid, output a_elem, output b_elem, output last, input ready);
  modport sink   (input valid, input a_elem, input b_elem, input last, output ready);
endinterface

// Result channel
interface nnck_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] covariance;
  logic               overflow;

  modport source (output valid, output covariance, output overflow, input ready);
  modport sink   (input valid, input covariance, input overflow, output ready);
endinterface

// ----- rtl/core/nnck_sqrt.sv -----
module nnck_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);
  import nnck_pkg::*;

  logic [63:0] rad;
  logic [34:0] rem;
  logic [4:0]  cnt;
  logic [34:0] cur;
  logic [34:0] trial;

  // One root bit per cycle, restoring recurrence
  assign cur   = {rem[32:0], rad[63:62]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[61:0], 2'b00};
      if (cur >= trial) begin
        rem  <= cur - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= cur;
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/core/nnck_div.sv -----
module nnck_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);
  import nnck_pkg::*;

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] cur;
  logic        fits;

  // One quotient bit per cycle, restoring
  assign cur  = {rem, quotient[63]};
  assign fits = cur >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= 32'(cur - {1'b0, dvs});
      end else begin
        rem <= cur[31:0];
      end
      quotient <= {quotient[62:0], fits};
    end
  end

endmodule

// ----- rtl/core/nnck_dp.sv -----
module nnck_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  nnck_pkg::dp_cmd_t                     cmd,
  output nnck_pkg::dp_stat_t                    stat,
  input  logic signed [nnck_pkg::ELEM_W-1:0]    a_elem,
  input  logic signed [nnck_pkg::ELEM_W-1:0]    b_elem,
  input  logic                                  cfg_write,
  input  logic [nnck_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nnck_pkg::CFG_W-1:0]            cfg_data,
  output logic signed [nnck_pkg::OUT_W-1:0]     covariance,
  output logic                                  overflow
);
  import nnck_pkg::*;

  // Truncating (toward zero) divide by 2^30
  function automatic logic signed [32:0] trunc30(input logic signed [65:0] x);
    logic signed [65:0] adj;
    adj = x[65] ? x + 66'sd1073741823 : x;
    return 33'(adj >>> 30);
  endfunction

  logic [CFG_W-1:0] gain_g;
  logic [CFG_W-1:0] var_gain;

  logic signed [ACC_W-1:0] sum_ab, sum_aa, sum_bb;
  logic [CNT_W-1:0]        count;
  logic                    sat_flag;

  logic signed [31:0] prod_ab, prod_aa, prod_bb;

  logic [ACC_W-1:0] m_u, m_v, m_w;
  logic             neg;
  logic [63:0]      mu, v, w, t;
  logic [5:0]       sv, sw, su;
  logic [30:0]      rv, rw, s, r;
  logic [31:0]      d;
  logic signed [32:0] acc;
  logic [2:0]       hidx;
  logic [18:0]      ang;

  logic signed [32:0] ma, mb;
  logic signed [65:0] p;
  logic               mul_en;

  logic [ACC_W-1:0] m_sel;
  logic signed [ACC_W-1:0] xs;
  logic [79:0]      gsum;
  logic [63:0]      gres;

  logic        sq_start;
  logic [63:0] sq_rad;
  logic        sq_busy;
  logic [31:0] sq_root;

  logic        div_start;
  logic        div_busy;
  logic [63:0] div_q;

  logic [6:0]  half_sh;
  logic [6:0]  nsh;
  logic [32:0] q_sh;

  logic signed [33:0] a_ang;
  logic [34:0]        a_rnd;

  logic [36:0] mag;
  logic        neg_eff;

  // Element products
  assign prod_ab = a_elem * b_elem;
  assign prod_aa = a_elem * a_elem;
  assign prod_bb = b_elem * b_elem;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_g   <= CFG_RESET;
      var_gain <= CFG_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_INV_LS_SQ) begin
        gain_g <= cfg_data;
      end else if (cfg_index == REG_VARIANCE) begin
        var_gain <= cfg_data;
      end
    end
  end

  // Accumulators; sums of at most MAX_LENGTH Q16.16 products stay inside 48 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_ab   <= '0;
      sum_aa   <= '0;
      sum_bb   <= '0;
      count    <= '0;
      sat_flag <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      sum_ab   <= '0;
      sum_aa   <= '0;
      sum_bb   <= '0;
      count    <= '0;
      sat_flag <= 1'b0;
    end else if (cmd.acc) begin
      if (count < CNT_W'(MAX_LENGTH)) begin
        sum_ab <= sum_ab + ACC_W'(prod_ab);
        sum_aa <= sum_aa + ACC_W'(prod_aa);
        sum_bb <= sum_bb + ACC_W'(prod_bb);
        count  <= count + CNT_W'(1);
      end else begin
        sat_flag <= 1'b1;
      end
    end
  end

  // Operand selects
  always_comb begin
    unique case (cmd.tgt)
      TGT_V:   m_sel = m_v;
      TGT_W:   m_sel = m_w;
      default: m_sel = m_u;
    endcase
  end

  assign xs = ONE_Q16 + sum_ab;

  // Shared multiplier operands
  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      OP_GLO: begin
        ma = $signed({1'b0, gain_g});
        mb = $signed({1'b0, m_sel[31:0]});
      end
      OP_GHI: begin
        ma = $signed({1'b0, gain_g});
        mb = $signed({17'b0, m_sel[47:32]});
      end
      OP_MULD: begin
        ma = $signed({2'b0, rv});
        mb = $signed({2'b0, rw});
      end
      OP_HMUL: begin
        ma = acc;
        mb = $signed({2'b0, r});
      end
      OP_MULSA: begin
        ma = $signed({2'b0, s});
        mb = acc;
      end
      OP_MULVA: begin
        ma = $signed({1'b0, var_gain});
        mb = $signed({14'b0, ang});
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      p <= ma * mb;
    end
  end

  // floor(g*m / 2^16) from the two partial products
  assign gsum = {p[47:0], 32'b0} + {16'b0, t};
  assign gres = gsum[79:16];

  // Square root source
  always_comb begin
    unique case (cmd.tgt)
      TGT_V:   sq_rad = v;
      TGT_W:   sq_rad = w;
      TGT_S:   sq_rad = (ONE_Q30 - 64'(r)) << 30;
      default: sq_rad = mu;
    endcase
  end
  assign sq_start  = (cmd.op == OP_SQ_GO);
  assign div_start = (cmd.op == OP_DIV_GO);

  nnck_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  nnck_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mu),
    .divisor  (d),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Ratio exponent and back shift
  assign half_sh = 7'((7'(sv) + 7'(sw)) >> 1);
  assign nsh     = 7'(su) - half_sh;
  assign q_sh    = div_q[32:0] >> nsh;

  // Angle and result rounding
  assign a_ang   = HALF_PI_Q30 - 34'(trunc30(p));
  assign a_rnd   = (a_ang[33] ? 35'd0 : {1'b0, a_ang}) + 35'd8192;
  assign mag     = 37'((53'(p[51:0]) + 53'd32768) >> 16);
  assign neg_eff = neg && !stat.mu_zero;

  // Working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_PREP: begin
        neg <= xs[ACC_W-1];
        m_u <= xs[ACC_W-1] ? ACC_W'(-xs) : xs;
        m_v <= ONE_Q16 + sum_aa;
        m_w <= ONE_Q16 + sum_bb;
        r   <= '0;
        sv  <= '0;
        sw  <= '0;
        su  <= '0;
      end
      OP_GHI: t <= p[63:0];
      OP_GWR: begin
        unique case (cmd.tgt)
          TGT_V:   v  <= gres + 64'd65536;
          TGT_W:   w  <= gres + 64'd65536;
          default: mu <= gres;
        endcase
      end
      OP_NORM: begin
        unique case (cmd.tgt)
          TGT_V: begin
            if (!stat.normed) begin
              v  <= v << 2;
              sv <= sv + 6'd2;
            end
          end
          TGT_W: begin
            if (!stat.normed) begin
              w  <= w << 2;
              sw <= sw + 6'd2;
            end
          end
          default: begin
            if (!stat.normed) begin
              mu <= mu << 1;
              su <= su + 6'd1;
            end
          end
        endcase
      end
      OP_SQ_WR: begin
        unique case (cmd.tgt)
          TGT_V:   rv <= sq_root[30:0];
          TGT_W:   rw <= sq_root[30:0];
          default: s  <= sq_root[30:0];
        endcase
      end
      OP_DWR: d <= p[61:30];
      OP_RWR: begin
        // Ratio above one comes from rounding and clamps silently
        if (7'(su) < half_sh) begin
          r <= ONE_Q30[30:0];
        end else if (q_sh > ONE_Q30[32:0]) begin
          r <= ONE_Q30[30:0];
        end else begin
          r <= q_sh[30:0];
        end
      end
      OP_HINIT: begin
        acc  <= asin_coef(3'd7);
        hidx <= 3'd6;
      end
      OP_HADD: begin
        acc  <= trunc30(p) + asin_coef(hidx);
        hidx <= hidx - 3'd1;
      end
      OP_AWR: ang <= a_rnd[32:14];
      OP_OUT: begin
        if (neg_eff) begin
          if (mag > 37'h0_8000_0000) begin
            covariance <= 32'sh8000_0000;
            overflow   <= 1'b1;
          end else begin
            covariance <= 32'(37'd0 - mag);
            overflow   <= sat_flag;
          end
        end else begin
          if (mag > 37'h0_7FFF_FFFF) begin
            covariance <= 32'sh7FFF_FFFF;
            overflow   <= 1'b1;
          end else begin
            covariance <= mag[31:0];
            overflow   <= sat_flag;
          end
        end
      end
      default: ;
    endcase
  end

  // Status back to the controller
  always_comb begin
    unique case (cmd.tgt)
      TGT_V:   stat.normed = |v[63:60];
      TGT_W:   stat.normed = |w[63:60];
      default: stat.normed = mu[62];
    endcase
    stat.mu_zero  = (mu == 64'd0);
    stat.sq_busy  = sq_busy;
    stat.div_busy = div_busy;
    stat.h_last   = (hidx == 3'd0);
  end

endmodule

// ----- rtl/core/nnck_ctrl.sv -----
module nnck_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output nnck_pkg::dp_cmd_t  cmd,
  input  nnck_pkg::dp_stat_t stat
);
  import nnck_pkg::*;

  localparam logic [4:0] ST_ACC   = 5'd0;
  localparam logic [4:0] ST_PREP  = 5'd1;
  localparam logic [4:0] ST_GLO   = 5'd2;
  localparam logic [4:0] ST_GHI   = 5'd3;
  localparam logic [4:0] ST_GWR   = 5'd4;
  localparam logic [4:0] ST_NORMV = 5'd5;
  localparam logic [4:0] ST_SQV   = 5'd6;
  localparam logic [4:0] ST_WV    = 5'd7;
  localparam logic [4:0] ST_NORMW = 5'd8;
  localparam logic [4:0] ST_SQW   = 5'd9;
  localparam logic [4:0] ST_WW    = 5'd10;
  localparam logic [4:0] ST_MULD  = 5'd11;
  localparam logic [4:0] ST_DWR   = 5'd12;
  localparam logic [4:0] ST_NORMU = 5'd13;
  localparam logic [4:0] ST_DIV   = 5'd14;
  localparam logic [4:0] ST_WD    = 5'd15;
  localparam logic [4:0] ST_HINIT = 5'd16;
  localparam logic [4:0] ST_HMUL  = 5'd17;
  localparam logic [4:0] ST_HADD  = 5'd18;
  localparam logic [4:0] ST_SQS   = 5'd19;
  localparam logic [4:0] ST_WS    = 5'd20;
  localparam logic [4:0] ST_MULSA = 5'd21;
  localparam logic [4:0] ST_AWR   = 5'd22;
  localparam logic [4:0] ST_MULVA = 5'd23;
  localparam logic [4:0] ST_OUT   = 5'd24;

  logic [4:0] state, state_next;
  tgt_t       gsel;
  logic       out_load;

  assign in_ready = (state == ST_ACC);
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  // Sequencer
  always_comb begin
    state_next = state;
    cmd.acc    = in_fire;
    cmd.op     = OP_NOP;
    cmd.tgt    = TGT_U;
    unique case (state)
      ST_ACC: begin
        if (in_fire && in_last) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.op     = OP_PREP;
        state_next = ST_GLO;
      end
      ST_GLO: begin
        cmd.op     = OP_GLO;
        cmd.tgt    = gsel;
        state_next = ST_GHI;
      end
      ST_GHI: begin
        cmd.op     = OP_GHI;
        cmd.tgt    = gsel;
        state_next = ST_GWR;
      end
      ST_GWR: begin
        cmd.op  = OP_GWR;
        cmd.tgt = gsel;
        if (gsel == TGT_W) begin
          state_next = stat.mu_zero ? ST_HINIT : ST_NORMV;
        end else begin
          state_next = ST_GLO;
        end
      end
      ST_NORMV: begin
        cmd.op  = OP_NORM;
        cmd.tgt = TGT_V;
        if (stat.normed) begin
          state_next = ST_SQV;
        end
      end
      ST_SQV: begin
        cmd.op     = OP_SQ_GO;
        cmd.tgt    = TGT_V;
        state_next = ST_WV;
      end
      ST_WV: begin
        cmd.tgt = TGT_V;
        if (!stat.sq_busy) begin
          cmd.op     = OP_SQ_WR;
          state_next = ST_NORMW;
        end
      end
      ST_NORMW: begin
        cmd.op  = OP_NORM;
        cmd.tgt = TGT_W;
        if (stat.normed) begin
          state_next = ST_SQW;
        end
      end
      ST_SQW: begin
        cmd.op     = OP_SQ_GO;
        cmd.tgt    = TGT_W;
        state_next = ST_WW;
      end
      ST_WW: begin
        cmd.tgt = TGT_W;
        if (!stat.sq_busy) begin
          cmd.op     = OP_SQ_WR;
          state_next = ST_MULD;
        end
      end
      ST_MULD: begin
        cmd.op     = OP_MULD;
        state_next = ST_DWR;
      end
      ST_DWR: begin
        cmd.op     = OP_DWR;
        state_next = ST_NORMU;
      end
      ST_NORMU: begin
        cmd.op  = OP_NORM;
        cmd.tgt = TGT_U;
        if (stat.normed) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op     = OP_DIV_GO;
        state_next = ST_WD;
      end
      ST_WD: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_RWR;
          state_next = ST_HINIT;
        end
      end
      ST_HINIT: begin
        cmd.op     = OP_HINIT;
        state_next = ST_HMUL;
      end
      ST_HMUL: begin
        cmd.op     = OP_HMUL;
        state_next = ST_HADD;
      end
      ST_HADD: begin
        cmd.op     = OP_HADD;
        state_next = stat.h_last ? ST_SQS : ST_HMUL;
      end
      ST_SQS: begin
        cmd.op     = OP_SQ_GO;
        cmd.tgt    = TGT_S;
        state_next = ST_WS;
      end
      ST_WS: begin
        cmd.tgt = TGT_S;
        if (!stat.sq_busy) begin
          cmd.op     = OP_SQ_WR;
          state_next = ST_MULSA;
        end
      end
      ST_MULSA: begin
        cmd.op     = OP_MULSA;
        state_next = ST_AWR;
      end
      ST_AWR: begin
        cmd.op     = OP_AWR;
        state_next = ST_MULVA;
      end
      ST_MULVA: begin
        cmd.op     = OP_MULVA;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          cmd.op     = OP_OUT;
          state_next = ST_ACC;
        end
      end
      default: state_next = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      gsel      <= TGT_U;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_PREP) begin
        gsel <= TGT_U;
      end else if (state == ST_GWR) begin
        gsel <= gsel + 2'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The closing pair of a vector stops intake until its result is built
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_last) |=> !in_ready)
    else $error("intake still open after last pair");

  a_sq_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SQ_GO) |-> !stat.sq_busy)
    else $error("square root restarted while busy");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_GO) |-> !stat.div_busy)
    else $error("divider restarted while busy");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |=> out_valid)
    else $error("result load did not raise valid");

endmodule

// ----- rtl/core/neural_network_covariance_kernel.sv -----
// Arcsine covariance kernel. Element pairs (Q8.8) are accepted one per cycle and
// summed into A.B, A.A and B.B; the pair marked last starts the finishing sequence,
// during which no pair is accepted: three gain multiplies on a shared 33x33
// multiplier, normalization of v, w and the numerator (one shift a cycle), three
// bit-serial square roots, a bit-serial divider, and a 7-step Horner arcsine.
// When the numerator is zero, the normalizations, the square roots of v and w and
// the divide are skipped. The finishing time is set mostly by the divider, the
// square root unit and the numerator normalization. The result
// (Q16.16, saturated, with an overflow flag) waits in an output register, so intake
// resumes while it is pending. Pairs past 1024 are dropped and raise the flag. Write
// the two configuration registers only while the block is idle.
module neural_network_covariance_kernel (
  input  logic                             clk,
  input  logic                             rst,
  nnck_item_if.sink                        item,
  nnck_result_if.source                    result,
  input  logic                             cfg_write,
  input  logic [nnck_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nnck_pkg::CFG_W-1:0]       cfg_data
);
  import nnck_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     in_fire;

  assign item.ready = in_ready;
  assign in_fire    = item.valid && in_ready;

  nnck_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_last   (item.last),
    .in_ready  (in_ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  nnck_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .a_elem     (item.a_elem),
    .b_elem     (item.b_elem),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .covariance (result.covariance),
    .overflow   (result.overflow)
  );

endmodule

// ----- tb/nnck_tb_if.sv -----
// Channel interfaces come from the RTL (nnck_item_if, nnck_result_if).
// This file carries the shared stimulus item type for the testbench.
package nnck_tb_pkg;
  typedef struct packed {
    logic signed [15:0] a_elem;
    logic signed [15:0] b_elem;
    logic               last;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] covariance;
    logic               overflow;
  } cov_t;
endpackage

// ----- tb/nnck_checker.sv -----
module nnck_checker (
  input  logic        clk,
  input  logic        rst,
  nnck_item_if        item,
  nnck_result_if      result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import nnck_pkg::*;
  import nnck_tb_pkg::*;

  localparam longint S48_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint S48_MIN = -S48_MAX - 1;

  logic [31:0] gain_g;
  logic [31:0] var_gain;
  longint      acc_ab, acc_aa, acc_bb;
  int          pair_count;
  bit          sat_seen;
  cov_t        cov_queue[$];

  function automatic longint clamp48(input longint x, inout bit f);
    if (x > S48_MAX) begin
      f = 1;
      return S48_MAX;
    end
    if (x < S48_MIN) begin
      f = 1;
      return S48_MIN;
    end
    return x;
  endfunction

  // floor(g*m/2^16)
  function automatic logic [63:0] scale_by_gain(input logic [31:0] g, input logic [63:0] m);
    logic [63:0] hi, lo;
    hi = {48'd0, g[31:16]};
    lo = {48'd0, g[15:0]};
    return hi * m + ((lo * m) >> 16);
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] normed_root(input logic [63:0] x, output int sh);
    int s;
    s = 0;
    if (x == 0) begin
      sh = 0;
      return 0;
    end
    while (x < (64'd1 << 60)) begin
      x <<= 2;
      s += 2;
    end
    while (x >= (64'd1 << 62)) begin
      x >>= 2;
      s -= 2;
    end
    sh = s;
    return floor_root(x);
  endfunction

  function automatic logic [63:0] cos_ratio(input logic [63:0] mu, input logic [63:0] v,
                                            input logic [63:0] w);
    int sv, sw, su, e;
    logic [63:0] d, q, rv, rw;
    su = 0;
    if (mu == 0) return 0;
    rv = normed_root(v, sv);
    rw = normed_root(w, sw);
    d = (rv * rw) >> 30;
    if (d == 0) return ONE_Q30;
    while (mu < (64'd1 << 62)) begin
      mu <<= 1;
      su++;
    end
    q = mu / d;
    e = (sv + sw) / 2 - su;
    if (e > 0) return ONE_Q30;
    if (e < 0) q = (-e >= 63) ? 64'd0 : (q >> (-e));
    return (q > ONE_Q30) ? ONE_Q30 : q;
  endfunction

  function automatic longint arcsine_q30(input logic [63:0] r);
    longint x, acc, s, a;
    longint coef[8];
    coef = '{1686629690, -230423709, 95540460, -53874249,
             33169905, -18348235, 7161955, -1355590};
    x = longint'(r);
    acc = coef[7];
    for (int i = 6; i >= 0; i--) acc = (acc * x) / 64'sd1073741824 + coef[i];
    s = longint'(floor_root(64'(64'sd1073741824 - x) << 30));
    a = 64'sd1686629713 - (s * acc) / 64'sd1073741824;
    return (a < 0) ? 0 : a;
  endfunction

  // Accumulate one pair; on last, return covariance expectation
  function automatic bit fold_pair(input pair_t p, output cov_t c);
    longint a, b, xs, ps, qs, ang;
    logic [63:0] mx, mu, v, w, r, mag;
    bit neg, f;
    f = sat_seen;
    a = p.a_elem;
    b = p.b_elem;
    if (pair_count < MAX_LENGTH) begin
      acc_ab = clamp48(acc_ab + a * b, f);
      acc_aa = clamp48(acc_aa + a * a, f);
      acc_bb = clamp48(acc_bb + b * b, f);
      pair_count++;
    end else begin
      f = 1;
    end
    sat_seen = f;
    if (!p.last) return 0;
    xs = clamp48(65536 + acc_ab, f);
    ps = clamp48(65536 + acc_aa, f);
    qs = clamp48(65536 + acc_bb, f);
    neg = xs < 0;
    mx = neg ? 64'(-xs) : 64'(xs);
    mu = scale_by_gain(gain_g, mx);
    v = 64'd65536 + scale_by_gain(gain_g, 64'(ps));
    w = 64'd65536 + scale_by_gain(gain_g, 64'(qs));
    r = cos_ratio(mu, v, w);
    ang = (arcsine_q30(r) + 8192) >>> 14;
    mag = ({32'd0, var_gain} * 64'(ang) + 64'd32768) >> 16;
    if (mu == 0) neg = 0;
    if (neg) begin
      if (mag > 64'd2147483648) begin
        mag = 64'd2147483648;
        f = 1;
      end
      c.covariance = 32'(64'd0 - mag);
    end else begin
      if (mag > 64'd2147483647) begin
        mag = 64'd2147483647;
        f = 1;
      end
      c.covariance = mag[31:0];
    end
    c.overflow = f;
    acc_ab = 0;
    acc_aa = 0;
    acc_bb = 0;
    pair_count = 0;
    sat_seen = 0;
    return 1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Watch both channels and the register port
  always @(posedge clk) begin
    cov_t c, exp_c;
    if (rst) begin
      gain_g <= CFG_RESET;
      var_gain <= CFG_RESET;
      acc_ab = 0;
      acc_aa = 0;
      acc_bb = 0;
      pair_count = 0;
      sat_seen = 0;
      cov_queue.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_INV_LS_SQ) gain_g <= cfg_data;
        else if (cfg_index == REG_VARIANCE) var_gain <= cfg_data;
      end
      if (item.valid && item.ready)
        if (fold_pair('{item.a_elem, item.b_elem, item.last}, c)) cov_queue.push_back(c);
      if (result.valid && result.ready) begin
        result_count <= result_count + 1;
        if (cov_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction cov=%0d", result.covariance));
        end else begin
          exp_c = cov_queue.pop_front();
          if (result.covariance !== exp_c.covariance)
            report_mismatch($sformatf("covariance got %0d want %0d",
                                      result.covariance, exp_c.covariance));
          if (result.overflow !== exp_c.overflow)
            report_mismatch($sformatf("overflow got %0b want %0b",
                                      result.overflow, exp_c.overflow));
        end
      end
    end
    pending_count <= cov_queue.size();
  end
endmodule

// ----- tb/neural_network_covariance_kernel_tb.sv -----
module neural_network_covariance_kernel_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nnck_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int fail_count, pending_count, result_count;
  int cycle_count = 0;
  int send_idle_pct = 19;
  int recv_idle_pct = 74;
  int pairs_sent = 0;
  int vectors_sent = 0;

  nnck_item_if item ();
  nnck_result_if result ();

  neural_network_covariance_kernel i_dut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  nnck_checker i_checker (
    .clk(clk), .rst(rst), .item(item), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    item.valid = 0;
    item.a_elem = 0;
    item.b_elem = 0;
    item.last = 0;
    result.ready = 0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[neural_network_covariance_kernel] ERROR");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    if (rst) result.ready <= 0;
    else result.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Present one pair, idling at random first; returns at the accepting edge
  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      item.valid <= 0;
      @(posedge clk);
    end
    item.valid <= 1;
    item.a_elem <= a;
    item.b_elem <= b;
    item.last <= l;
    @(posedge clk iff item.ready);
    pairs_sent++;
    if (l) vectors_sent++;
  endtask

  task automatic settle();
    item.valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(512)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic rand_vector(input int maxlen);
    int n;
    logic [15:0] a;
    n = $urandom_range(maxlen, 1);
    for (int i = 0; i < n; i++) begin
      a = rand_elem();
      // sometimes B equals A
      send_pair(a, ($urandom_range(7) == 0) ? a : rand_elem(), i == n - 1);
    end
  endtask

  function automatic logic [31:0] rand_cfg();
    case ($urandom_range(5))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0001_0000;
      default: return $urandom_range(32'h0004_0000, 1);
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, zero numerator, equal vectors, single pair, over-length, register extremes
    send_pair(16'h0000, 16'h0000, 1);
    send_pair(16'h7FFF, 16'h7FFF, 1);
    send_pair(16'h8000, 16'h7FFF, 1);
    send_pair(16'h8000, 16'h8000, 1);
    send_pair(16'h0100, 16'hFF00, 1);   // A.B = -1 -> numerator zero
    send_pair(16'hFFFF, 16'h0001, 0);
    send_pair(16'h5555, 16'hAAAA, 1);
    send_pair(16'h0200, 16'h0200, 0);
    send_pair(16'h0300, 16'h0300, 1);
    // over-length vector: pairs past the maximum are dropped and flagged
    for (int i = 0; i < MAX_LENGTH + 3; i++)
      send_pair(16'h7FFF, 16'h8000, i == MAX_LENGTH + 2);
    settle();
    write_reg(REG_INV_LS_SQ, 32'hFFFF_FFFF);
    write_reg(REG_VARIANCE, 32'hFFFF_FFFF);
    write_reg(2'd3, 32'h1234_5678);     // unused index
    send_pair(16'h7FFF, 16'h7FFF, 1);
    send_pair(16'h8000, 16'h7FFF, 1);
    send_pair(16'h0040, 16'hFFC0, 1);
    settle();
    write_reg(REG_INV_LS_SQ, 32'd1);
    write_reg(REG_VARIANCE, 32'd1);
    send_pair(16'h7FFF, 16'h8000, 1);
    send_pair(16'h1234, 16'h4321, 1);

    // Random phases with changing idling and settings
    for (int ph = 0; ph < 9; ph++) begin
      settle();
      if (ph == 3) begin
        send_idle_pct = 74;
        recv_idle_pct = 19;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_INV_LS_SQ, rand_cfg());
      write_reg(REG_VARIANCE, rand_cfg());
      for (int v = 0; v < 9; v++) rand_vector(($urandom_range(9) == 0) ? 40 : 6);
    end
    settle();

    $display("sent %0d element pairs in %0d vectors, %0d results checked",
             pairs_sent, vectors_sent, result_count);
    $display("covered extremes, sign cases, over-length vectors, register extremes, stalls");
    if (fail_count == 0) begin
      $display("[neural_network_covariance_kernel] OK");
    end else begin
      $display("[neural_network_covariance_kernel] ERROR");
    end
    $finish;
  end
endmodule
